// ----- sv/stat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stat_pkg
// Shared types and codes for the sorted term accumulation table.
// ----------------------------------------------------------------------------
package stat_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned ExpoW   = 16;
  localparam int unsigned StatusW = 3;

  localparam logic [StatusW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [StatusW-1:0] ST_MERGED    = 3'd1;
  localparam logic [StatusW-1:0] ST_CANCELLED = 3'd2;
  localparam logic [StatusW-1:0] ST_ZERO      = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd4;
  localparam logic [StatusW-1:0] ST_READ      = 3'd5;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [ExpoW-1:0]        expo;
    logic signed [CoefW-1:0] coef;
  } stat_term_t;

endpackage

// ----- sv/stat_term_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stat_term_ram
// Single write port, single registered read port store of table terms.
// ----------------------------------------------------------------------------
module stat_term_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  stat_pkg::stat_term_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output stat_pkg::stat_term_t rd_data
);

  stat_pkg::stat_term_t mem [DEPTH];
  stat_pkg::stat_term_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/sorted_term_accumulate_table_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_term_accumulate_table_core
// Keeps a sparse polynomial as terms sorted by descending exponent, merges,
// inserts or cancels added terms and reads the whole table out in order.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   operation, coefficient, exponent
//   out_     output     out_valid / out_ready term_coefficient, term_exponent,
//                                             status, last, empty_res
//
// An add reads and compares stored terms in turn through the single read
// port of the store; an insert or removal shifts terms by a read and a write
// each. A read-out reads and presents each stored term; a zero add or empty
// read is answered in the accept cycle. Reset clears state, count, out_valid.
// A stalled result holds in the output register; requests wait until it
// has been taken and the sequencer is idle.
// ----------------------------------------------------------------------------
module sorted_term_accumulate_table_core #(
  parameter int unsigned MAX_TERMS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic signed [31:0]          in_coefficient,
  input  logic [15:0]                 in_exponent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_term_coefficient,
  output logic [15:0]                 out_term_exponent,
  output logic [2:0]                  out_status,
  output logic                        out_last,
  output logic                        out_empty_res
);

  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam int unsigned AW = $clog2(MAX_TERMS);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_TERMS);
  localparam logic [CW-1:0] ONE      = CW'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCMP   = 4'd2;
  localparam logic [3:0] S_INS_RD = 4'd3;
  localparam logic [3:0] S_INS_WR = 4'd4;
  localparam logic [3:0] S_REM_RD = 4'd5;
  localparam logic [3:0] S_REM_WR = 4'd6;
  localparam logic [3:0] S_RO_RD  = 4'd7;
  localparam logic [3:0] S_RO_OUT = 4'd8;

  logic [3:0]                state_r, state_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic signed [31:0]        coef_r, coef_nxt;
  logic [15:0]               expo_r, expo_nxt;

  logic                      out_valid_r;
  logic signed [31:0]        out_coef_r;
  logic [15:0]               out_expo_r;
  logic [2:0]                out_status_r;
  logic                      out_last_r;
  logic                      out_empty_r;

  logic                      out_load;
  logic signed [31:0]        ld_coef;
  logic [15:0]               ld_expo;
  logic [2:0]                ld_status;
  logic                      ld_last;
  logic                      ld_empty;
  logic                      out_free;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  stat_pkg::stat_term_t      wr_data;
  logic [AW-1:0]             rd_addr;
  stat_pkg::stat_term_t      rd_data;
  logic [CW-1:0]             rd_idx;
  logic [31:0]               sum;
  logic                      accept;

  stat_term_ram #(
    .DEPTH (MAX_TERMS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign sum      = 32'(rd_data.coef) + 32'(coef_r);

  always_comb begin
    unique case (state_r)
      S_INS_RD: rd_idx = idx_r - ONE;
      S_REM_RD: rd_idx = idx_r + ONE;
      default:  rd_idx = idx_r;
    endcase
  end
  assign rd_addr = rd_idx[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    coef_nxt  = coef_r;
    expo_nxt  = expo_r;
    out_load  = 1'b0;
    ld_coef   = coef_r;
    ld_expo   = expo_r;
    ld_status = stat_pkg::ST_INSERTED;
    ld_last   = 1'b1;
    ld_empty  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = rd_data;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          coef_nxt = in_coefficient;
          expo_nxt = in_exponent;
          idx_nxt  = '0;
          if (in_operation == stat_pkg::OP_READ) begin
            if (cnt_r == '0) begin
              out_load  = 1'b1;
              ld_coef   = '0;
              ld_expo   = '0;
              ld_status = stat_pkg::ST_READ;
              ld_empty  = 1'b1;
            end else begin
              state_nxt = S_RO_RD;
            end
          end else if (in_coefficient == '0) begin
            out_load  = 1'b1;
            ld_coef   = '0;
            ld_expo   = in_exponent;
            ld_status = stat_pkg::ST_ZERO;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (idx_r == cnt_r) begin
          if (cnt_r == FULL_CNT) begin
            out_load  = 1'b1;
            ld_status = stat_pkg::ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = idx_r;
            idx_nxt   = cnt_r;
            state_nxt = S_INS_RD;
          end
        end else begin
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        if (rd_data.expo > expo_r) begin
          idx_nxt   = idx_r + ONE;
          state_nxt = S_SRD;
        end else if (rd_data.expo == expo_r) begin
          out_load = 1'b1;
          if (sum == '0) begin
            ld_coef   = '0;
            ld_status = stat_pkg::ST_CANCELLED;
            cnt_nxt   = cnt_r - ONE;
            state_nxt = S_REM_RD;
          end else begin
            ld_coef      = $signed(sum);
            ld_status    = stat_pkg::ST_MERGED;
            wr_en        = 1'b1;
            wr_data.expo = expo_r;
            wr_data.coef = $signed(sum);
            state_nxt    = S_IDLE;
          end
        end else if (cnt_r == FULL_CNT) begin
          out_load  = 1'b1;
          ld_status = stat_pkg::ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt   = idx_r;
          idx_nxt   = cnt_r;
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (idx_r == pos_r) begin
          wr_en        = 1'b1;
          wr_data.expo = expo_r;
          wr_data.coef = coef_r;
          cnt_nxt      = cnt_r + ONE;
          out_load     = 1'b1;
          ld_status    = stat_pkg::ST_INSERTED;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r - ONE;
        state_nxt = S_INS_RD;
      end
      S_REM_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REM_WR;
        end
      end
      S_REM_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r + ONE;
        state_nxt = S_REM_RD;
      end
      S_RO_RD: begin
        state_nxt = S_RO_OUT;
      end
      S_RO_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_coef   = rd_data.coef;
          ld_expo   = rd_data.expo;
          ld_status = stat_pkg::ST_READ;
          ld_last   = (idx_r + ONE) == cnt_r;
          idx_nxt   = idx_r + ONE;
          state_nxt = ld_last ? S_IDLE : S_RO_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    coef_r <= coef_nxt;
    expo_r <= expo_nxt;
    if (out_load) begin
      out_coef_r   <= ld_coef;
      out_expo_r   <= ld_expo;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
      out_empty_r  <= ld_empty;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_term_coefficient = out_coef_r;
  assign out_term_exponent    = out_expo_r;
  assign out_status           = out_status_r;
  assign out_last             = out_last_r;
  assign out_empty_res        = out_empty_r;

  // The term count never exceeds the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("term count beyond table depth");

  // A non-zero add always leaves the idle state to search the table.
  a_add_search: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == stat_pkg::OP_ADD && in_coefficient != '0)
    |=> state_r == S_SRD)
    else $error("non-zero add did not start a search");

  // Read-out only ever addresses stored terms.
  a_ro_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RO_OUT) |-> idx_r < cnt_r)
    else $error("read-out index beyond stored terms");

  // A result is never loaded over one that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten");

endmodule
